@@ hw/rtl/fpbm_pkg.sv @@
// Package: shared types, constants and request/status codes of the frame pool buffer manager.
package fpbm_pkg;

  localparam int MaxFrames = 16;
  localparam int PosW      = $clog2(MaxFrames);
  localparam int NumW      = $clog2(MaxFrames + 1);
  localparam int CntW      = 8;
  localparam int PendW     = 8;

  localparam logic [NumW-1:0]  FrameCountRst = NumW'(MaxFrames);
  localparam logic [CntW-1:0]  CntMax        = '1;
  localparam logic [PendW-1:0] PendMax       = '1;

  localparam logic [3:0] ReqRingAcq  = 4'd0;
  localparam logic [3:0] ReqCommit   = 4'd1;
  localparam logic [3:0] ReqRingDeq  = 4'd2;
  localparam logic [3:0] ReqRelease  = 4'd3;
  localparam logic [3:0] ReqPoolAcq  = 4'd4;
  localparam logic [3:0] ReqEnqueue  = 4'd5;
  localparam logic [3:0] ReqPoolDeq  = 4'd6;
  localparam logic [3:0] ReqRef      = 4'd7;
  localparam logic [3:0] ReqUnref    = 4'd8;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoSlot = 2'd1;
  localparam logic [1:0] StEmpty  = 2'd2;
  localparam logic [1:0] StOvf    = 2'd3;

  typedef struct packed {
    logic [3:0] req_type;
    logic [3:0] frame_sel;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] frame_out;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

@@ hw/rtl/frame_pool_buffer_manager.sv @@
// Top level: frame pool buffer manager, controller plus datapath.
//
// Usage: one request beat on the input channel (req_type, frame_sel) gives
// exactly one result beat (status, frame_out) on the output channel, in order.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// The request is registered when accepted; the execute step writes the result
// into the output register and raises out_valid. Accept and execute steps
// alternate; the input stalls while a request executes. The execute step reads
// one count, runs the free and busy slot priority encoders over the configured
// slots and writes at most one count back. The result sits in an output
// register, so the next request is accepted while a finished result still
// waits; a stalled receiver holds the execute step until the register frees,
// and the input then stalls. The user must see that frame_count is written
// through cfg_we_i/cfg_wdata_i only while the block is idle; the block does not
// enforce this. Reset clears all counts, ring positions, occupancy and pending
// count, sets frame_count to 16, and leaves both channels empty.
module frame_pool_buffer_manager (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  fpbm_pkg::req_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fpbm_pkg::rsp_t            out_data_o,
  input  logic                      cfg_we_i,
  input  logic [fpbm_pkg::NumW-1:0] cfg_wdata_i
);
  import fpbm_pkg::*;

  ctrl_t ctrl;

  fpbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  fpbm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .req_i       (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (out_data_o)
  );

endmodule

@@ hw/rtl/fpbm_ctrl.sv @@
// Controller: request handshake, execute sequencing and output beat valid.
module fpbm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fpbm_pkg::ctrl_t ctrl_o
);
  import fpbm_pkg::*;

  typedef enum logic {SIdle, SExec} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = (state_q != SIdle);
  assign out_valid_o  = out_valid_q;
  assign ctrl_o.load  = (state_q == SIdle) && in_valid_i;
  assign ctrl_o.exec  = (state_q == SExec) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        SIdle: begin
          if (in_valid_i) state_q <= SExec;
        end
        SExec: begin
          if (out_free) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
      if (ctrl_o.exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/fpbm_dp.sv @@
// Datapath: slot reference counts, ring positions, pending count and result register.
module fpbm_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fpbm_pkg::ctrl_t             ctrl_i,
  input  fpbm_pkg::req_t              req_i,
  input  logic                        cfg_we_i,
  input  logic [fpbm_pkg::NumW-1:0]   cfg_wdata_i,
  output fpbm_pkg::rsp_t              rsp_o
);
  import fpbm_pkg::*;

  logic [CntW-1:0]  cnt_q [MaxFrames];
  logic [PosW-1:0]  wp_q, wp_d;
  logic [PosW-1:0]  rp_q, rp_d;
  logic [NumW-1:0]  occ_q, occ_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [NumW-1:0]  frame_count_q;
  req_t             req_q;
  rsp_t             rsp_q, rsp_d;

  logic [NumW-1:0]  n;
  logic [PosW-1:0]  rd_addr;
  logic [CntW-1:0]  rd_cnt;
  logic [MaxFrames-1:0] free_vec, busy_vec;
  logic             free_hit, busy_hit;
  logic [PosW-1:0]  free_idx, busy_idx;
  logic             sel_ok;
  logic             wr_en;
  logic [PosW-1:0]  wr_addr;
  logic [CntW-1:0]  wr_cnt;

  function automatic logic [PosW-1:0] advance(logic [PosW-1:0] pos, logic [NumW-1:0] cnt);
    logic [PosW:0] nxt;
    nxt = {1'b0, pos} + 1'b1;
    return (NumW'(nxt) >= cnt) ? '0 : nxt[PosW-1:0];
  endfunction

  always_comb begin
    if (frame_count_q == '0) begin
      n = NumW'(1);
    end else if (frame_count_q > NumW'(MaxFrames)) begin
      n = NumW'(MaxFrames);
    end else begin
      n = frame_count_q;
    end
  end

  assign sel_ok = {{(NumW-PosW){1'b0}}, req_q.frame_sel} < n;

  always_comb begin
    case (req_q.req_type)
      ReqRingAcq: rd_addr = wp_q;
      ReqRingDeq: rd_addr = rp_q;
      default:    rd_addr = req_q.frame_sel;
    endcase
  end

  assign rd_cnt = cnt_q[rd_addr];

  for (genvar g = 0; g < MaxFrames; g++) begin : g_scan
    assign free_vec[g] = (cnt_q[g] == '0) && (NumW'(g) < n);
    assign busy_vec[g] = (cnt_q[g] >= CntW'(2)) && (NumW'(g) < n);
  end

  always_comb begin
    free_hit = 1'b0;
    busy_hit = 1'b0;
    free_idx = '0;
    busy_idx = '0;
    for (int i = MaxFrames - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_hit = 1'b1;
        free_idx = PosW'(i);
      end
      if (busy_vec[i]) begin
        busy_hit = 1'b1;
        busy_idx = PosW'(i);
      end
    end
  end

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    occ_d   = occ_q;
    pend_d  = pend_q;
    wr_en   = 1'b0;
    wr_addr = req_q.frame_sel;
    wr_cnt  = rd_cnt;
    rsp_d.status    = StOk;
    rsp_d.frame_out = '0;
    case (req_q.req_type)
      ReqRingAcq: begin
        if (occ_q >= n || rd_cnt != '0) begin
          rsp_d.status = StNoSlot;
        end else begin
          wr_en   = 1'b1;
          wr_addr = wp_q;
          wr_cnt  = CntW'(1);
          rsp_d.frame_out = wp_q;
        end
      end
      ReqCommit: begin
        if (occ_q >= n) begin
          rsp_d.status = StOvf;
        end else begin
          wp_d  = advance(wp_q, n);
          occ_d = occ_q + 1'b1;
        end
      end
      ReqRingDeq: begin
        if (occ_q == '0 || rd_cnt == '0) begin
          rsp_d.status = StEmpty;
        end else begin
          rsp_d.frame_out = rp_q;
          rp_d  = advance(rp_q, n);
          occ_d = occ_q - 1'b1;
        end
      end
      ReqRelease: begin
        if (!sel_ok) begin
          rsp_d.status = StNoSlot;
        end else begin
          wr_en  = 1'b1;
          wr_cnt = '0;
        end
      end
      ReqPoolAcq: begin
        if (!free_hit) begin
          rsp_d.status = StNoSlot;
        end else begin
          wr_en   = 1'b1;
          wr_addr = free_idx;
          wr_cnt  = CntW'(1);
          rsp_d.frame_out = free_idx;
        end
      end
      ReqEnqueue: begin
        if (!sel_ok) begin
          rsp_d.status = StNoSlot;
        end else if (rd_cnt == CntMax || pend_q == PendMax) begin
          rsp_d.status = StOvf;
        end else begin
          wr_en  = 1'b1;
          wr_cnt = rd_cnt + 1'b1;
          pend_d = pend_q + 1'b1;
        end
      end
      ReqPoolDeq: begin
        if (pend_q == '0) begin
          rsp_d.status = StEmpty;
        end else begin
          pend_d = pend_q - 1'b1;
          if (busy_hit) begin
            rsp_d.frame_out = busy_idx;
          end else begin
            rsp_d.status = StEmpty;
          end
        end
      end
      ReqRef: begin
        if (!sel_ok) begin
          rsp_d.status = StNoSlot;
        end else if (rd_cnt == CntMax) begin
          rsp_d.status = StOvf;
        end else begin
          wr_en  = 1'b1;
          wr_cnt = rd_cnt + 1'b1;
        end
      end
      ReqUnref: begin
        if (!sel_ok) begin
          rsp_d.status = StNoSlot;
        end else if (rd_cnt == '0) begin
          rsp_d.status = StOvf;
        end else begin
          wr_en  = 1'b1;
          wr_cnt = rd_cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxFrames; i++) cnt_q[i] <= '0;
      wp_q          <= '0;
      rp_q          <= '0;
      occ_q         <= '0;
      pend_q        <= '0;
      frame_count_q <= FrameCountRst;
    end else begin
      if (cfg_we_i) frame_count_q <= cfg_wdata_i;
      if (ctrl_i.exec) begin
        wp_q   <= wp_d;
        rp_q   <= rp_d;
        occ_q  <= occ_d;
        pend_q <= pend_d;
        if (wr_en) cnt_q[wr_addr] <= wr_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) req_q <= req_i;
    if (ctrl_i.exec) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= NumW'(MaxFrames))
    else $error("occupancy above pool size");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.exec |=> (rsp_q.status == StOk || rsp_q.frame_out == '0))
    else $error("slot index given with failing status");

  a_commit_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.exec && req_q.req_type == ReqCommit && rsp_d.status == StOk
    |=> occ_q == $past(occ_q) + 1'b1)
    else $error("commit did not raise occupancy");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.exec |=> occ_q == $past(occ_q) && pend_q == $past(pend_q))
    else $error("ring state changed without a request");
`endif

endmodule
